[rtl/lir_pkg.sv]
// Package for the linear interpolation resampler: widths, constants and sequencer codes.
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 24;
    localparam int STEP_BITS     = 32;
    localparam int WEIGHT_BITS   = 16;
    localparam int POS_BITS      = STEP_BITS + 1;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + WEIGHT_BITS + 1;

    localparam logic [POS_BITS-1:0]  POS_ONE   = POS_BITS'(64'd1 << FRACTION_BITS);
    localparam logic [POS_BITS-1:0]  POS_TWO   = POS_BITS'(64'd2 << FRACTION_BITS);
    localparam logic [POS_BITS-1:0]  MIN_STEP  = POS_BITS'(64'd1 << (FRACTION_BITS - 5));
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(64'd1 << FRACTION_BITS);
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(64'd1 << (WEIGHT_BITS - 1));

    localparam int ST_BITS = 2;
    localparam logic [ST_BITS-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_BITS-1:0] ST_CHECK = 2'd1;
    localparam logic [ST_BITS-1:0] ST_MUL   = 2'd2;
    localparam logic [ST_BITS-1:0] ST_OUT   = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [POS_BITS-1:0]           pos_t;

endpackage

[rtl/linear_interp_resampler.sv]
// Streaming linear interpolation resampler with one shared multiply-round unit.
// Each result passes through the check, multiply and round/output states in order; the
// output state waits while out_ready holds off a full output register.
// in_ready stays low from an accepted beat until all of its results are out, and through
// the stream clear after a final beat. A first sample that is not final is only stored.
// Reset (rst_n, async, active low): step = 1.0, stream state cleared, output empty.
`timescale 1ns / 1ps

module linear_interp_resampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lir_pkg::STEP_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 final_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                                 run_end,
    output logic                                 stream_end
);
    import lir_pkg::*;

    logic [ST_BITS-1:0]   st_reg, st_next;
    logic [STEP_BITS-1:0] step_reg;
    sample_t              prev_reg, prev_next;
    sample_t              x_reg, x_next;
    logic                 last_reg, last_next;
    logic                 have_prev_reg, have_prev_next;
    logic                 phase_b_reg, phase_b_next;
    pos_t                 pos_reg, pos_next;
    pos_t                 adv_reg, adv_next;
    logic                 is_last_reg, is_last_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;

    logic                 out_valid_reg, out_valid_next;
    sample_t              out_sample_reg, out_sample_next;
    logic                 run_end_reg, run_end_next;
    logic                 stream_end_reg, stream_end_next;

    pos_t                        inc;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [WEIGHT_BITS:0] weight;
    logic signed [PROD_BITS-1:0] rounded;
    logic                        out_free;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (st_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_end    = run_end_reg;
    assign stream_end = stream_end_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign inc      = ({1'b0, step_reg} < MIN_STEP) ? MIN_STEP : {1'b0, step_reg};
    assign diff     = DIFF_BITS'(x_reg) - DIFF_BITS'(prev_reg);
    assign weight   = $signed({1'b0, pos_reg[FRACTION_BITS-1 -: WEIGHT_BITS]});
    // floor((prod + half) / 2^16) is an arithmetic shift
    assign rounded  = (prod_reg + $signed(ROUND_HALF)) >>> WEIGHT_BITS;

    always_comb
    begin
        st_next         = st_reg;
        prev_next       = prev_reg;
        x_next          = x_reg;
        last_next       = last_reg;
        have_prev_next  = have_prev_reg;
        phase_b_next    = phase_b_reg;
        pos_next        = pos_reg;
        adv_next        = adv_reg;
        is_last_next    = is_last_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        run_end_next    = run_end_reg;
        stream_end_next = stream_end_reg;

        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = sample;
                    last_next = final_sample;
                    if (have_prev_reg)
                    begin
                        phase_b_next = 1'b0;
                        st_next      = ST_CHECK;
                    end
                    else
                    begin
                        prev_next      = sample;
                        have_prev_next = 1'b1;
                        if (final_sample)
                        begin
                            phase_b_next = 1'b1;
                            st_next      = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (pos_reg < POS_ONE)
                begin
                    st_next = ST_MUL;
                end
                else if (!phase_b_reg)
                begin
                    pos_next       = pos_reg - POS_ONE;
                    prev_next      = x_reg;
                    have_prev_next = 1'b1;
                    if (last_reg)
                    begin
                        // hold phase: prev equals x, so outputs repeat the final sample
                        phase_b_next = 1'b1;
                    end
                    else
                    begin
                        st_next = ST_IDLE;
                    end
                end
                else
                begin
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    pos_next       = '0;
                    st_next        = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next = PROD_BITS'(diff) * PROD_BITS'(weight);
                adv_next  = pos_reg + inc;
                if (phase_b_reg)
                begin
                    is_last_next = (adv_next >= POS_ONE);
                end
                else
                begin
                    is_last_next = (adv_next >= POS_ONE) &&
                                   (!last_reg || (adv_next >= POS_TWO));
                end
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = prev_reg + SAMPLE_BITS'(rounded);
                    run_end_next    = is_last_reg;
                    stream_end_next = is_last_reg && last_reg;
                    pos_next        = adv_reg;
                    st_next         = ST_CHECK;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            step_reg      <= STEP_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_b_reg   <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            phase_b_reg   <= phase_b_next;
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        last_reg       <= last_next;
        adv_reg        <= adv_next;
        is_last_reg    <= is_last_next;
        prod_reg       <= prod_next;
        out_sample_reg <= out_sample_next;
        run_end_reg    <= run_end_next;
        stream_end_reg <= stream_end_next;
    end

    a_stream_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_end)
        else $error("stream_end without run_end");

    a_mul_in_interval: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_MUL |-> pos_reg < POS_ONE)
        else $error("multiply with position outside interval");

    a_fresh_stream_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_IDLE && !have_prev_reg |-> pos_reg == '0)
        else $error("stream state not cleared");

endmodule

[bench/linear_interp_resampler_tb.sv]
// Self-checking bench for the linear interpolation resampler: directed and random streams.
`timescale 1ns / 1ps

module linear_interp_resampler_tb;

    import lir_pkg::*;

    localparam int ITEM_TARGET   = 430;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        sample_t value;
        logic    run_end;
        logic    stream_end;
    } out_beat_t;

    // Tracks the stream position and step, and queues the outputs each sample should cause.
    class interp_tracker;
        logic [STEP_BITS-1:0] step;
        sample_t              prev_sample;
        bit                   have_prev;
        pos_t                 next_pos;
        out_beat_t            expected_outputs[$];
        int                   mismatches;

        function new();
            step        = STEP_RESET;
            prev_sample = '0;
            have_prev   = 1'b0;
            next_pos    = '0;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void set_step(logic [STEP_BITS-1:0] value);
            step = value;
        endfunction

        // x0 + round_half_up((x1 - x0) * w / 2^16), w = top fraction bits
        function sample_t lerp(sample_t x0, sample_t x1, logic [FRACTION_BITS-1:0] frac);
            longint w;
            longint d;
            longint p;
            w = longint'(frac[FRACTION_BITS-1 -: WEIGHT_BITS]);
            d = longint'(x1) - longint'(x0);
            p = (d * w + (longint'(1) << (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
            return sample_t'(longint'(x0) + p);
        endfunction

        function void push_value(sample_t v);
            out_beat_t b;
            b.value      = v;
            b.run_end    = 1'b0;
            b.stream_end = 1'b0;
            expected_outputs.insert(expected_outputs.size(), b);
        endfunction

        function void note_sample(sample_t x, bit last);
            pos_t inc;
            int   n0;
            n0  = expected_outputs.size();
            inc = (pos_t'(step) < MIN_STEP) ? MIN_STEP : pos_t'(step);
            if (have_prev)
            begin
                while (next_pos < POS_ONE)
                begin
                    push_value(lerp(prev_sample, x, next_pos[FRACTION_BITS-1:0]));
                    next_pos += inc;
                end
                next_pos -= POS_ONE;
            end
            prev_sample = x;
            have_prev   = 1'b1;
            if (last)
            begin
                // tail positions below N hold the final sample
                while (next_pos < POS_ONE)
                begin
                    push_value(x);
                    next_pos += inc;
                end
                if (expected_outputs.size() > n0)
                    expected_outputs[expected_outputs.size()-1].stream_end = 1'b1;
                prev_sample = '0;
                have_prev   = 1'b0;
                next_pos    = '0;
            end
            if (expected_outputs.size() > n0)
                expected_outputs[expected_outputs.size()-1].run_end = 1'b1;
        endfunction

        function void check_output(logic [SAMPLE_BITS-1:0] v, logic re, logic se);
            out_beat_t e;
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected output beat %0d run_end=%b stream_end=%b",
                             $realtime, $signed(v), re, se);
                return;
            end
            e = expected_outputs.pop_front();
            if (e.value !== v || e.run_end !== re || e.stream_end !== se)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: expected %0d/%b/%b got %0d/%b/%b (sample/run_end/stream_end)",
                             $realtime, e.value, e.run_end, e.stream_end,
                             $signed(v), re, se);
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [STEP_BITS-1:0]   cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    sample_t                sample       = '0;
    logic                   final_sample = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    sample_t                out_sample;
    logic                   run_end;
    logic                   stream_end;

    interp_tracker sb = new();

    int in_gap_max  = 10;
    int out_gap_max = 10;
    int hold_cycles = 0;
    int items_sent  = 0;
    int idle_count  = 0;

    linear_interp_resampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .final_sample (final_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_sample   (out_sample),
        .run_end      (run_end),
        .stream_end   (stream_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Called at a clock edge; the caller lets no time pass between beats so valid
    // is either refreshed or dropped in the step of the previous acceptance.
    task automatic send_sample(sample_t x, bit last);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample       <= x;
        final_sample <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(x, last);
        items_sent++;
    endtask

    task automatic send_stream(int len, bit with_final);
        sample_t x;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else
                x = sample_t'($urandom);
            send_sample(x, with_final && (i == len - 1));
        end
    endtask

    // Sender pause: nothing offered until every queued output has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(logic [STEP_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_step(value);
        @(posedge clk);
    endtask

    // Output side back-pressure; a requested hold-off replaces one draw.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = $urandom_range(0, out_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output(out_sample, run_end, stream_end);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [STEP_BITS-1:0] new_step;
        int                   streams;
        int                   len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unity step: straight copy, sample extremes
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        // first sample of a stream is also its last
        send_sample(16'sd12345, 1'b1);
        wait_drained();

        // smallest step: 32 outputs per interval, 64 on a final beat
        write_step(32'h0008_0000);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        wait_drained();

        // largest step: stream ends with nothing left to emit
        write_step(32'hFFFF_FFFF);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd7, 1'b1);
        send_sample(-16'sd5, 1'b1);
        wait_drained();

        write_step(32'h0180_0000);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b1);
        wait_drained();

        // half step: weight lands on exact halves, rounding ties go upward
        write_step(32'h0080_0000);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        wait_drained();

        // output held off while input keeps coming, so the block backs up
        write_step(STEP_RESET);
        in_gap_max  = 0;
        hold_cycles = HOLD_CYCLES;
        send_stream(40, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: new_step = STEP_RESET;
                1: new_step = $urandom_range(32'h0100_0000, 32'h0008_0000);
                2: new_step = $urandom_range(32'h0400_0000, 32'h0100_0000);
                3: new_step = $urandom_range(32'hFFFF_FFFF, 32'h0008_0000);
                4: new_step = STEP_RESET + $urandom_range(0, 511) - 256;
                default: new_step = MIN_STEP[STEP_BITS-1:0];
            endcase
            write_step(new_step);
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            streams = $urandom_range(1, 4);
            for (int s = 0; s < streams; s++)
            begin
                len = (new_step < 32'h0010_0000) ? $urandom_range(1, 4) : $urandom_range(1, 40);
                // now and then a phase ends mid-stream and the next step carries on
                send_stream(len, !(s == streams - 1 && $urandom_range(0, 3) == 0));
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
